// ===== sv/sdmc_pkg.sv =====
// shared types and constants for the snooping direct-mapped cache
// no dependencies
`default_nettype none
package sdmc_pkg;
    localparam int ADDR_W     = 12;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = 48;
    localparam int COST_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int DEF_LINE_COUNT     = 64;
    localparam int DEF_WORDS_PER_LINE = 4;
    localparam int DEF_MEMORY_WORDS   = 4096;
    localparam logic [COST_W-1:0] HIT_COST_RST  = 8'd1;
    localparam logic [COST_W-1:0] MISS_COST_RST = 8'd16;

    typedef enum logic [2:0] {
        OP_CPU_RD  = 3'd0,
        OP_CPU_WR  = 3'd1,
        OP_SNP_RD  = 3'd2,
        OP_SNP_RDX = 3'd3,
        OP_SNP_INV = 3'd4,
        OP_SNP_WB  = 3'd5,
        OP_RSV6    = 3'd6,
        OP_RSV7    = 3'd7
    } t_op;

    typedef enum logic [0:0] {
        CFG_HIT_COST  = 1'b0,
        CFG_MISS_COST = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic latch;      // take the request
        logic look;       // lookup cycle, hit flag is live
        logic flush_sel;  // line ram read walks the word counter
        logic flush_we;   // victim word to backing memory
        logic fill_we;    // backing word into the line
        logic fill_done;  // new tag, line valid and clean, miss cost
        logic w_clr;
        logic w_inc;
        logic cpu_write;
        logic hit_add;
        logic inval;
        logic clean;
        logic emit;
        logic rd_sel;
        logic clear_we;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic hit;
        logic dirty;      // valid and dirty
        logic last_word;
        logic clear_last;
    } t_stat;
endpackage
`default_nettype wire

// ===== sv/sdmc_ram.sv =====
// generic simple dual-port ram, one write and one registered read
// no dependencies
`default_nettype none
module sdmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/sdmc_ctrl.sv =====
// controller state machine of the cache
// depends on sdmc_pkg
`default_nettype none
module sdmc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire sdmc_pkg::t_stat i_stat,
    output sdmc_pkg::t_cmd     o_cmd
);
    import sdmc_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_TAG   = 9'b000000100,
        S_LOOK  = 9'b000001000,
        S_FL_RD = 9'b000010000,
        S_FL_WR = 9'b000100000,
        S_FI_RD = 9'b001000000,
        S_FI_WR = 9'b010000000,
        S_ACC   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_rd2, n_rd2;
    logic   cpu;

    assign busy = (r_state != S_IDLE) || r_rd2;
    assign cpu  = (i_stat.op == OP_CPU_RD) || (i_stat.op == OP_CPU_WR);

    always_comb begin
        n_state = r_state;
        n_rd2   = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_we = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (r_rd2) begin
                    // read after a fill
                    o_cmd.emit   = 1'b1;
                    o_cmd.rd_sel = 1'b1;
                end else if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_TAG;
                end
            end
            S_TAG: n_state = S_LOOK;
            S_LOOK: begin
                o_cmd.look = 1'b1;
                o_cmd.w_clr = 1'b1;
                n_state = S_IDLE;
                if (cpu) begin
                    if (i_stat.hit) begin
                        o_cmd.hit_add = 1'b1;
                        o_cmd.emit    = 1'b1;
                        o_cmd.rd_sel  = (i_stat.op == OP_CPU_RD);
                        o_cmd.cpu_write = (i_stat.op == OP_CPU_WR);
                    end else if (i_stat.dirty) begin
                        n_state = S_FL_RD;
                    end else begin
                        n_state = S_FI_RD;
                    end
                end else if (i_stat.op == OP_SNP_RD || i_stat.op == OP_SNP_WB) begin
                    if (i_stat.hit && i_stat.dirty) begin
                        n_state = S_FL_RD;
                    end else begin
                        o_cmd.emit = 1'b1;
                    end
                end else begin
                    o_cmd.inval = i_stat.hit &&
                        (i_stat.op == OP_SNP_RDX || i_stat.op == OP_SNP_INV);
                    o_cmd.emit  = 1'b1;
                end
            end
            S_FL_RD: begin
                o_cmd.flush_sel = 1'b1;
                n_state = S_FL_WR;
            end
            S_FL_WR: begin
                o_cmd.flush_sel = 1'b1;
                o_cmd.flush_we  = 1'b1;
                o_cmd.w_inc     = 1'b1;
                n_state = S_FL_RD;
                if (i_stat.last_word) begin
                    o_cmd.clean = 1'b1;
                    o_cmd.w_clr = 1'b1;
                    if (cpu) begin
                        n_state = S_FI_RD;
                    end else begin
                        o_cmd.inval = (i_stat.op == OP_SNP_WB);
                        o_cmd.emit  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_FI_RD: n_state = S_FI_WR;
            S_FI_WR: begin
                o_cmd.fill_we = 1'b1;
                o_cmd.w_inc   = 1'b1;
                n_state = S_FI_RD;
                if (i_stat.last_word) begin
                    o_cmd.fill_done = 1'b1;
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = S_IDLE;
                if (i_stat.op == OP_CPU_WR) begin
                    o_cmd.cpu_write = 1'b1;
                    o_cmd.emit      = 1'b1;
                end else begin
                    n_rd2 = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_rd2   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd2   <= n_rd2;
        end
    end
endmodule
`default_nettype wire

// ===== sv/sdmc_dp.sv =====
// datapath: tag, line and backing memories, line flags, cost registers, counter
// depends on sdmc_pkg and sdmc_ram
`default_nettype none
module sdmc_dp #(
    parameter int LINE_COUNT     = sdmc_pkg::DEF_LINE_COUNT,
    parameter int WORDS_PER_LINE = sdmc_pkg::DEF_WORDS_PER_LINE,
    parameter int MEMORY_WORDS   = sdmc_pkg::DEF_MEMORY_WORDS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire sdmc_pkg::t_cmd                 i_cmd,
    output sdmc_pkg::t_stat                     o_stat,
    input  wire logic [2:0]                     i_op,
    input  wire logic [sdmc_pkg::ADDR_W-1:0]    i_address,
    input  wire logic [sdmc_pkg::DATA_W-1:0]    i_write_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [sdmc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [sdmc_pkg::COST_W-1:0]    i_cfg_wdata,
    output logic                                o_valid,
    output logic [sdmc_pkg::DATA_W-1:0]         o_read_data,
    output logic                                o_hit,
    output logic [sdmc_pkg::CNT_W-1:0]          o_cycle_total
);
    import sdmc_pkg::*;

    localparam int IW     = $clog2(LINE_COUNT);
    localparam int OW     = $clog2(WORDS_PER_LINE);
    localparam int OW_S   = (OW > 0) ? OW : 1;
    localparam int TAG_RAW = ADDR_W - IW - OW;
    localparam int TAG_W  = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int DA_W   = $clog2(LINE_COUNT * WORDS_PER_LINE);
    localparam int MEM_AW = $clog2(MEMORY_WORDS);

    t_op               r_op;
    logic [IW-1:0]     r_idx;
    logic [OW_S-1:0]   r_off;
    logic [TAG_W-1:0]  r_tag;
    logic [DATA_W-1:0] r_wdata;
    logic [OW_S-1:0]   r_w;
    logic [LINE_COUNT-1:0] r_valid, r_dirty;
    logic [COST_W-1:0] r_hit_cost, r_miss_cost;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [MEM_AW-1:0] r_clr;
    logic              r_hit;
    logic              n_hit;

    logic [TAG_W-1:0]  tag_rdata;
    logic [DATA_W-1:0] line_rdata, mem_rdata;
    logic [OW_S-1:0]   line_w;
    logic [DA_W-1:0]   line_raddr, line_waddr;
    logic              line_we;
    logic [DATA_W-1:0] line_wdata;
    logic [MEM_AW-1:0] mem_raddr, mem_waddr;
    logic              mem_we;
    logic [DATA_W-1:0] mem_wdata;
    logic              hit_now;

    function automatic logic [MEM_AW-1:0] slot(logic [TAG_W-1:0] t, logic [IW-1:0] ix,
                                               logic [OW_S-1:0] w);
        logic [31:0] a;
        a = (32'(t) * LINE_COUNT + 32'(ix)) * WORDS_PER_LINE + 32'(w);
        return MEM_AW'(a % MEMORY_WORDS);
    endfunction

    assign hit_now = r_valid[r_idx] && (tag_rdata == r_tag) && (r_op <= OP_SNP_WB);
    assign line_w  = i_cmd.flush_sel ? r_w : r_off;
    assign line_raddr = DA_W'(32'(r_idx) * WORDS_PER_LINE + 32'(line_w));
    assign line_waddr = DA_W'(32'(r_idx) * WORDS_PER_LINE +
                              32'(i_cmd.fill_we ? r_w : r_off));
    assign line_we    = i_cmd.fill_we || i_cmd.cpu_write;
    assign line_wdata = i_cmd.fill_we ? mem_rdata : r_wdata;
    assign mem_raddr  = slot(r_tag, r_idx, r_w);
    assign mem_we     = i_cmd.flush_we || i_cmd.clear_we;
    assign mem_waddr  = i_cmd.clear_we ? r_clr : slot(tag_rdata, r_idx, r_w);
    assign mem_wdata  = i_cmd.clear_we ? DATA_W'(r_clr) : line_rdata;

    assign o_stat.op         = r_op;
    assign o_stat.hit        = hit_now;
    assign o_stat.dirty      = r_valid[r_idx] && r_dirty[r_idx];
    assign o_stat.last_word  = (r_w == OW_S'(WORDS_PER_LINE - 1));
    assign o_stat.clear_last = (r_clr == MEM_AW'(MEMORY_WORDS - 1));

    sdmc_ram #(.WIDTH(TAG_W), .DEPTH(LINE_COUNT)) u_tag_ram (
        .i_clk(i_clk), .i_we(i_cmd.fill_done), .i_waddr(r_idx), .i_wdata(r_tag),
        .i_raddr(r_idx), .o_rdata(tag_rdata)
    );
    sdmc_ram #(.WIDTH(DATA_W), .DEPTH(LINE_COUNT * WORDS_PER_LINE)) u_line_ram (
        .i_clk(i_clk), .i_we(line_we), .i_waddr(line_waddr), .i_wdata(line_wdata),
        .i_raddr(line_raddr), .o_rdata(line_rdata)
    );
    sdmc_ram #(.WIDTH(DATA_W), .DEPTH(MEMORY_WORDS)) u_mem_ram (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(mem_wdata),
        .i_raddr(mem_raddr), .o_rdata(mem_rdata)
    );

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.hit_add) begin
            n_cnt = r_cnt + CNT_W'(r_hit_cost);
        end else if (i_cmd.fill_done) begin
            n_cnt = r_cnt + CNT_W'(r_miss_cost);
        end
        n_hit = i_cmd.look ? hit_now : r_hit;
    end

    // request fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op    <= t_op'(i_op);
            r_off   <= OW_S'(i_address % WORDS_PER_LINE);
            r_idx   <= IW'((i_address / WORDS_PER_LINE) % LINE_COUNT);
            r_tag   <= TAG_W'(i_address / (WORDS_PER_LINE * LINE_COUNT));
            r_wdata <= i_write_data;
        end
        if (i_cmd.emit) begin
            o_read_data   <= i_cmd.rd_sel ? line_rdata : '0;
            o_hit         <= n_hit;
            o_cycle_total <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_dirty     <= '0;
            r_cnt       <= '0;
            r_hit_cost  <= HIT_COST_RST;
            r_miss_cost <= MISS_COST_RST;
            r_clr       <= '0;
            r_w         <= '0;
            r_hit       <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
            r_cnt   <= n_cnt;
            r_hit   <= n_hit;
            if (i_cmd.clear_we) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.w_clr) begin
                r_w <= '0;
            end else if (i_cmd.w_inc) begin
                r_w <= r_w + 1'b1;
            end
            if (i_cmd.fill_done) begin
                r_valid[r_idx] <= 1'b1;
                r_dirty[r_idx] <= 1'b0;
            end
            if (i_cmd.clean) begin
                r_dirty[r_idx] <= 1'b0;
            end
            if (i_cmd.inval) begin
                r_valid[r_idx] <= 1'b0;
                r_dirty[r_idx] <= 1'b0;
            end
            if (i_cmd.cpu_write) begin
                r_dirty[r_idx] <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_HIT_COST:  r_hit_cost  <= i_cfg_wdata;
                    CFG_MISS_COST: r_miss_cost <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ===== sv/snooping_direct_mapped_cache.sv =====
// top level of the snooping direct-mapped write-back cache
// depends on sdmc_pkg, sdmc_ctrl, sdmc_dp
//
// channel   signals                                     handshake
// request   i_op, i_address, i_write_data               start & !busy
// result    o_read_data, o_hit, o_cycle_total           o_valid, one cycle
// config    i_cfg_we, i_cfg_index, i_cfg_wdata          i_cfg_we
//
// a hit or a snoop with no write-back passes the tag and lookup states, then raises
// o_valid in the same cycle that busy drops and the next request can be taken
// a write-back walks each word through a flush read and a flush write state, a fill
// each word through a fill read and a fill write state and then the access state
// after reset a clearing pass writes each backing word with its address,
// with busy high; config writes are taken throughout
// the receiver cannot stall the result
`default_nettype none
module snooping_direct_mapped_cache #(
    parameter int LINE_COUNT     = sdmc_pkg::DEF_LINE_COUNT,
    parameter int WORDS_PER_LINE = sdmc_pkg::DEF_WORDS_PER_LINE,
    parameter int MEMORY_WORDS   = sdmc_pkg::DEF_MEMORY_WORDS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [2:0]                     i_op,
    input  wire logic [sdmc_pkg::ADDR_W-1:0]    i_address,
    input  wire logic [sdmc_pkg::DATA_W-1:0]    i_write_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [sdmc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [sdmc_pkg::COST_W-1:0]    i_cfg_wdata,
    output logic                                o_valid,
    output logic [sdmc_pkg::DATA_W-1:0]         o_read_data,
    output logic                                o_hit,
    output logic [sdmc_pkg::CNT_W-1:0]          o_cycle_total
);
    import sdmc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sdmc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_stat(stat), .o_cmd(cmd)
    );

    sdmc_dp #(
        .LINE_COUNT(LINE_COUNT), .WORDS_PER_LINE(WORDS_PER_LINE),
        .MEMORY_WORDS(MEMORY_WORDS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_op(i_op), .i_address(i_address), .i_write_data(i_write_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata),
        .o_valid(o_valid), .o_read_data(o_read_data), .o_hit(o_hit),
        .o_cycle_total(o_cycle_total)
    );
endmodule
`default_nettype wire

// ===== bench/snooping_direct_mapped_cache_tb.sv =====
// self-checking bench for the snooping direct-mapped write-back cache
// depends on sdmc_pkg and snooping_direct_mapped_cache
`timescale 1ns / 100ps
`default_nettype none
module snooping_direct_mapped_cache_tb;
    import sdmc_pkg::*;

    localparam int LINES = 64;
    localparam int WPL   = 4;
    localparam int MEMW  = 4096;
    localparam int LIMIT = 20000;

    typedef struct {
        t_op                op;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  wdata;
        int                 gap;
    } t_req;

    typedef struct {
        logic [DATA_W-1:0] rdata;
        logic              hit;
        logic [CNT_W-1:0]  total;
    } t_rsp;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [2:0]            i_op = '0;
    logic [ADDR_W-1:0]     i_address = '0;
    logic [DATA_W-1:0]     i_write_data = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [COST_W-1:0]     i_cfg_wdata = '0;
    logic                  o_valid;
    logic [DATA_W-1:0]     o_read_data;
    logic                  o_hit;
    logic [CNT_W-1:0]      o_cycle_total;

    snooping_direct_mapped_cache i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_op(i_op), .i_address(i_address), .i_write_data(i_write_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata),
        .o_valid(o_valid), .o_read_data(o_read_data), .o_hit(o_hit),
        .o_cycle_total(o_cycle_total)
    );

    always #2 i_clk = ~i_clk;

    // cache shadow
    logic [COST_W-1:0] hit_cost, miss_cost;
    logic              sh_valid [LINES];
    logic              sh_dirty [LINES];
    logic [3:0]        sh_tag   [LINES];
    logic [DATA_W-1:0] sh_words [LINES*WPL];
    logic [DATA_W-1:0] sh_mem   [MEMW];
    logic [CNT_W-1:0]  sh_cycles;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   errors = 0;
    int   idle_cycles = 0;
    bit   stim_done = 1'b0;
    int   gap_left = 0;
    logic acc_q = 1'b0;

    function automatic void write_back_line(input int idx);
        for (int w = 0; w < WPL; w++)
            sh_mem[(int'(sh_tag[idx]) * LINES + idx) * WPL + w] = sh_words[idx*WPL + w];
        sh_dirty[idx] = 1'b0;
    endfunction

    function automatic t_rsp cache_access(input t_req r);
        t_rsp res;
        int off, idx;
        logic [3:0] tag;
        logic hit;
        off = r.addr % WPL;
        idx = (r.addr / WPL) % LINES;
        tag = 4'(r.addr / (WPL * LINES));
        hit = sh_valid[idx] && sh_tag[idx] == tag;
        res.rdata = '0;
        case (r.op)
            OP_CPU_RD, OP_CPU_WR: begin
                if (hit) begin
                    sh_cycles += hit_cost;
                end else begin
                    if (sh_valid[idx] && sh_dirty[idx]) write_back_line(idx);
                    for (int w = 0; w < WPL; w++)
                        sh_words[idx*WPL + w] = sh_mem[(int'(tag) * LINES + idx) * WPL + w];
                    sh_tag[idx] = tag;
                    sh_valid[idx] = 1'b1;
                    sh_dirty[idx] = 1'b0;
                    sh_cycles += miss_cost;
                end
                if (r.op == OP_CPU_RD) begin
                    res.rdata = sh_words[idx*WPL + off];
                end else begin
                    sh_words[idx*WPL + off] = r.wdata;
                    sh_dirty[idx] = 1'b1;
                end
            end
            OP_SNP_RD: if (hit && sh_dirty[idx]) write_back_line(idx);
            OP_SNP_RDX, OP_SNP_INV: begin
                if (hit) begin
                    sh_valid[idx] = 1'b0;
                    sh_dirty[idx] = 1'b0;
                end
            end
            OP_SNP_WB: begin
                if (hit && sh_dirty[idx]) begin
                    write_back_line(idx);
                    sh_valid[idx] = 1'b0;
                end
            end
            default: hit = 1'b0;
        endcase
        res.hit = hit;
        res.total = sh_cycles;
        return res;
    endfunction

    function automatic t_op rand_op();
        int k;
        k = $urandom_range(0, 99);
        if (k < 35) return OP_CPU_RD;
        if (k < 65) return OP_CPU_WR;
        if (k < 75) return OP_SNP_RD;
        if (k < 82) return OP_SNP_RDX;
        if (k < 88) return OP_SNP_INV;
        if (k < 96) return OP_SNP_WB;
        return k < 98 ? OP_RSV6 : OP_RSV7;
    endfunction

    task automatic add_req(input t_op op, input logic [ADDR_W-1:0] a,
                           input logic [DATA_W-1:0] d);
        t_req r;
        r.op = op;
        r.addr = a;
        r.wdata = d;
        r.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        pending_reqs.push_back(r);
    endtask

    // addresses mostly fall in a few lines so hits, victims and snoops collide
    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [ADDR_W-1:0] a;
        a = ADDR_W'($urandom);
        if ($urandom_range(0, 3) != 0) a[7:4] = 4'd0;
        return a;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || busy || start)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [COST_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == CFG_HIT_COST) hit_cost = v;
        else miss_cost = v;
    endtask

    // driver
    always @(negedge i_clk) begin
        t_req r;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !acc_q) begin
            // request waits for busy to drop
        end else if (start) begin
            start <= 1'b0;
            gap_left <= (pending_reqs.size() != 0) ? pending_reqs[0].gap : 0;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
        end else if (pending_reqs.size() != 0) begin
            r = pending_reqs.pop_front();
            start <= 1'b1;
            i_op <= r.op;
            i_address <= r.addr;
            i_write_data <= r.wdata;
        end
    end

    // acceptance is seen at the rising edge; prediction happens there too
    always @(posedge i_clk) begin
        t_req r;
        acc_q <= start && !busy;
        if (start && !busy) begin
            r.op = t_op'(i_op);
            r.addr = i_address;
            r.wdata = i_write_data;
            r.gap = 0;
            expected_rsps.push_back(cache_access(r));
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_rsps.size() == 0) begin
                $display("%0t: result with none expected: rd %h hit %b total %h",
                         $realtime, o_read_data, o_hit, o_cycle_total);
                errors++;
            end else begin
                t_rsp e;
                e = expected_rsps.pop_front();
                if (e.rdata !== o_read_data) begin
                    $display("%0t: read_data expected %h actual %h",
                             $realtime, e.rdata, o_read_data);
                    errors++;
                end
                if (e.hit !== o_hit) begin
                    $display("%0t: hit expected %b actual %b", $realtime, e.hit, o_hit);
                    errors++;
                end
                if (e.total !== o_cycle_total) begin
                    $display("%0t: cycle_total expected %h actual %h",
                             $realtime, e.total, o_cycle_total);
                    errors++;
                end
            end
        end
    end

    // watchdog, allows for the clearing pass after reset
    always @(posedge i_clk) begin
        if (o_valid || (start && !busy) || stim_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= LIMIT + MEMW) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        hit_cost = HIT_COST_RST;
        miss_cost = MISS_COST_RST;
        sh_cycles = '0;
        for (int i = 0; i < LINES; i++) begin
            sh_valid[i] = 1'b0;
            sh_dirty[i] = 1'b0;
            sh_tag[i] = '0;
        end
        for (int i = 0; i < LINES*WPL; i++) sh_words[i] = '0;
        for (int i = 0; i < MEMW; i++) sh_mem[i] = DATA_W'(i);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: fill, hit, dirty victim, each snoop flavor, reserved ops
        add_req(OP_CPU_RD, 12'h000, '0);
        add_req(OP_CPU_RD, 12'h003, '0);
        add_req(OP_CPU_WR, 12'h001, 32'hFFFF_FFFF);
        add_req(OP_CPU_RD, 12'h101, '0);
        add_req(OP_CPU_RD, 12'h001, '0);
        add_req(OP_CPU_WR, 12'hFFF, 32'hA5A5_5A5A);
        add_req(OP_SNP_RD, 12'hFFF, '0);
        add_req(OP_SNP_RD, 12'hFFF, '0);
        add_req(OP_CPU_WR, 12'hFFC, 32'h0000_0001);
        add_req(OP_SNP_WB, 12'hFFD, '0);
        add_req(OP_CPU_RD, 12'hFFC, '0);
        add_req(OP_SNP_WB, 12'hFFC, '0);
        add_req(OP_CPU_WR, 12'h810, 32'h8000_0000);
        add_req(OP_SNP_RDX, 12'h812, '0);
        add_req(OP_CPU_RD, 12'h810, '0);
        add_req(OP_CPU_WR, 12'h420, 32'h1234_5678);
        add_req(OP_SNP_INV, 12'h420, '0);
        add_req(OP_SNP_INV, 12'h420, '0);
        add_req(OP_SNP_RD, 12'h555, '0);
        add_req(OP_RSV6, 12'h000, 32'hFFFF_FFFF);
        add_req(OP_RSV7, 12'hFFF, '0);
        add_req(OP_CPU_RD, 12'h420, '0);
        wait_drained();

        cfg_write(CFG_HIT_COST, 8'd0);
        cfg_write(CFG_MISS_COST, 8'd255);
        for (int p = 0; p < 4; p++) begin
            for (int n = 0; n < 260; n++) add_req(rand_op(), rand_addr(), $urandom);
            wait_drained();
            cfg_write(CFG_HIT_COST, p == 0 ? 8'd255 : 8'($urandom));
            cfg_write(CFG_MISS_COST, p == 1 ? 8'd0 : 8'($urandom));
        end

        stim_done = 1'b1;
        if (errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
